[design/bbs_pkg.sv]
// ----------------------------------------------------------------------------
// bbs_pkg: shared types and constants for the Bezier surface evaluator
// Item formats, queue depth, pipeline widths and reset control points.
// ----------------------------------------------------------------------------
`default_nettype none

package bbs_pkg;

  localparam int MAX_RESOLUTION = 256;
  localparam int RES_W          = 9;
  localparam int QDEPTH         = 4;
  localparam int QPTR_W         = $clog2(QDEPTH);
  localparam int DIV_STAGES     = 4;
  localparam int DIV_BITS       = 16 / DIV_STAGES;
  localparam int RAW_W          = 52;
  localparam int PROD_W         = 50;
  localparam int SUM_W          = 54;

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_EVAL = 1'b1
  } kind_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } cp_t;

  // one queued transaction, already classified by the front end
  typedef struct packed {
    kind_t       kind;
    logic [1:0]  row;
    logic [1:0]  col;
    cp_t         pt;
    logic [7:0]  a;
    logic [7:0]  b;
    logic        sat_a;
    logic        sat_b;
    logic [15:0] vidx;
  } q_item_t;

  function automatic cp_t cp_reset(input logic [1:0] row, input logic [1:0] col);
    cp_t p;
    p.x = col[1] ? 16'sd100 : 16'sd0;
    p.y = (col == 2'd1 || col == 2'd2) ? 16'sd100 : 16'sd0;
    case (row)
      2'd0:    p.z = 16'sd0;
      2'd1:    p.z = 16'sd100;
      2'd2:    p.z = 16'sd200;
      default: p.z = 16'sd300;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

[design/bbs_queue.sv]
// ----------------------------------------------------------------------------
// bbs_queue: short transaction queue between front and back end
// Small register FIFO with full and empty flags.
// ----------------------------------------------------------------------------
`default_nettype none

module bbs_queue (
  input  wire             clk,
  input  wire             rst,
  input  wire             push,
  input  bbs_pkg::q_item_t push_item,
  input  wire             pop,
  output bbs_pkg::q_item_t head,
  output logic            full,
  output logic            empty
);
  import bbs_pkg::*;

  q_item_t               mem [QDEPTH];
  logic [QPTR_W-1:0]     wr_ptr;
  logic [QPTR_W-1:0]     rd_ptr;
  logic [QPTR_W:0]       count;

  assign full  = (count == (QPTR_W+1)'(QDEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

[design/bbs_front.sv]
// ----------------------------------------------------------------------------
// bbs_front: input acceptance and classification
// Holds the resolution register, clamps it, flags out-of-range grid steps
// and forms the vertex index before queueing the transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module bbs_front (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      in_valid,
  output logic                     in_stall,
  input  wire                      kind,
  input  wire  [1:0]               point_row,
  input  wire  [1:0]               point_col,
  input  wire  signed [15:0]       coord_x,
  input  wire  signed [15:0]       coord_y,
  input  wire  signed [15:0]       coord_z,
  input  wire  [7:0]               grid_a,
  input  wire  [7:0]               grid_b,
  input  wire                      cfg_valid,
  output logic                     cfg_ready,
  input  wire  [bbs_pkg::RES_W-1:0] grid_resolution,
  input  wire                      q_full,
  output logic                     q_push,
  output bbs_pkg::q_item_t         q_item,
  output logic [bbs_pkg::RES_W-1:0] res_eff
);
  import bbs_pkg::*;

  logic [RES_W-1:0] res_reg;
  logic [17:0]      vidx_full;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_reg <= RES_W'(32);
    end else if (cfg_valid) begin
      res_reg <= grid_resolution;
    end
  end

  always_comb begin
    if (res_reg == '0)
      res_eff = RES_W'(1);
    else if (res_reg > RES_W'(MAX_RESOLUTION))
      res_eff = RES_W'(MAX_RESOLUTION);
    else
      res_eff = res_reg;
  end

  assign in_stall  = q_full;
  assign q_push    = in_valid && !q_full;
  assign vidx_full = 18'(grid_a * res_eff) + 18'(grid_b);

  always_comb begin
    q_item.kind  = kind_t'(kind);
    q_item.row   = point_row;
    q_item.col   = point_col;
    q_item.pt.x  = coord_x;
    q_item.pt.y  = coord_y;
    q_item.pt.z  = coord_z;
    q_item.a     = grid_a;
    q_item.b     = grid_b;
    q_item.sat_a = ({1'b0, grid_a} >= res_eff);
    q_item.sat_b = ({1'b0, grid_b} >= res_eff);
    q_item.vidx  = vidx_full[15:0];
  end

endmodule

`default_nettype wire

[design/bbs_back.sv]
// ----------------------------------------------------------------------------
// bbs_back: evaluation pipeline
// Pipelined u/v divider, Bernstein weights, 16 weighted products per axis,
// adder tree and Q16.8 rounding. Loads update the control points in order.
// ----------------------------------------------------------------------------
`default_nettype none

module bbs_back (
  input  wire                       clk,
  input  wire                       rst,
  input  bbs_pkg::q_item_t          head,
  input  wire                       q_empty,
  output logic                      q_pop,
  input  wire  [bbs_pkg::RES_W-1:0] res_eff,
  output logic                      out_valid,
  input  wire                       out_stall,
  output logic signed [23:0]        surf_x,
  output logic signed [23:0]        surf_y,
  output logic signed [23:0]        surf_z,
  output logic [15:0]               tex_u,
  output logic [15:0]               tex_v,
  output logic [15:0]               vertex_index
);
  import bbs_pkg::*;

  typedef struct packed {
    logic       valid;
    q_item_t    it;
  } side_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] tu;
    logic [15:0] tv;
    logic [15:0] vidx;
  } tail_t;

  typedef struct packed {
    logic [RES_W-1:0] rem;
    logic [15:0]      q;
  } div_t;

  function automatic div_t div_step(input div_t d, input logic [RES_W-1:0] r);
    div_t            o;
    logic [RES_W:0]  t;
    o = d;
    for (int k = 0; k < DIV_BITS; k++) begin
      t = {o.rem, 1'b0};
      if (t >= {1'b0, r}) begin
        t   = t - {1'b0, r};
        o.q = {o.q[14:0], 1'b1};
      end else begin
        o.q = {o.q[14:0], 1'b0};
      end
      o.rem = t[RES_W-1:0];
    end
    return o;
  endfunction

  function automatic logic signed [23:0] to_q16_8(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-1:0] t;
    logic signed [SUM_W-1:0] r;
    t = s + SUM_W'(25'sd8388608);
    r = t >>> 24;
    if (r > SUM_W'(24'sd8388607))
      return 24'sh7FFFFF;
    else if (r < -SUM_W'(25'sd8388608))
      return 24'sh800000;
    else
      return r[23:0];
  endfunction

  logic adv;
  assign adv   = !out_valid || !out_stall;
  assign q_pop = adv && !q_empty;

  side_t sd [0:8];
  div_t  dv [2][0:DIV_STAGES];
  tail_t tl [5:13];

  logic [16:0]      uu [2];
  logic [16:0]      ss [2];
  logic [33:0]      s2 [2];
  logic [33:0]      us [2];
  logic [33:0]      u2 [2];
  logic [RAW_W-1:0] raw [2][4];
  logic [16:0]      w [2][4];
  logic [33:0]      ww [16];
  logic signed [PROD_W-1:0] pr [3][16];
  logic signed [SUM_W-1:0]  l1 [3][8];
  logic signed [SUM_W-1:0]  l2 [3][4];
  logic signed [SUM_W-1:0]  l3 [3][2];
  logic signed [SUM_W-1:0]  l4 [3];
  cp_t cp [16];

  logic [15:0] tfin [2];
  logic        sat4 [2];

  assign sat4[0] = sd[DIV_STAGES].it.sat_a;
  assign sat4[1] = sd[DIV_STAGES].it.sat_b;
  assign tfin[0] = sat4[0] ? 16'hFFFF : dv[0][DIV_STAGES].q;
  assign tfin[1] = sat4[1] ? 16'hFFFF : dv[1][DIV_STAGES].q;

  // valid bits (reset) and payload pipeline (no reset)
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= 8; i++) sd[i].valid <= 1'b0;
      for (int i = 5; i <= 13; i++) tl[i].valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      sd[0].valid <= q_pop;
      for (int i = 1; i <= 8; i++) sd[i].valid <= sd[i-1].valid;
      tl[5].valid <= sd[DIV_STAGES].valid && (sd[DIV_STAGES].it.kind == KIND_EVAL);
      for (int i = 6; i <= 13; i++) tl[i].valid <= tl[i-1].valid;
      out_valid <= tl[13].valid;
    end
    if (adv) begin
      sd[0].it <= head;
      for (int i = 1; i <= 8; i++) sd[i].it <= sd[i-1].it;
      dv[0][0] <= '{rem: RES_W'(head.a), q: '0};
      dv[1][0] <= '{rem: RES_W'(head.b), q: '0};
      for (int j = 0; j < 2; j++) begin
        for (int i = 1; i <= DIV_STAGES; i++) dv[j][i] <= div_step(dv[j][i-1], res_eff);
        uu[j] <= {1'b0, tfin[j]};
        ss[j] <= 17'h10000 - {1'b0, tfin[j]};
        s2[j] <= 34'((17'h10000 - {1'b0, tfin[j]}) * (17'h10000 - {1'b0, tfin[j]}));
        us[j] <= 34'({1'b0, tfin[j]} * (17'h10000 - {1'b0, tfin[j]}));
        u2[j] <= 34'({1'b0, tfin[j]} * {1'b0, tfin[j]});
        raw[j][0] <= RAW_W'(s2[j] * ss[j]);
        raw[j][1] <= RAW_W'(us[j] * ss[j]) * RAW_W'(3);
        raw[j][2] <= RAW_W'(u2[j] * ss[j]) * RAW_W'(3);
        raw[j][3] <= RAW_W'(u2[j] * uu[j]);
        for (int k = 0; k < 4; k++)
          w[j][k] <= 17'((raw[j][k] + RAW_W'(64'h80000000)) >> 32);
      end
      tl[5].tu   <= tfin[0];
      tl[5].tv   <= tfin[1];
      tl[5].vidx <= sd[DIV_STAGES].it.vidx;
      for (int i = 6; i <= 13; i++) begin
        tl[i].tu   <= tl[i-1].tu;
        tl[i].tv   <= tl[i-1].tv;
        tl[i].vidx <= tl[i-1].vidx;
      end
      // row weights come from v, column weights from u
      for (int r = 0; r < 4; r++)
        for (int c = 0; c < 4; c++)
          ww[r*4+c] <= 34'(w[1][r] * w[0][c]);
      for (int i = 0; i < 16; i++) begin
        pr[0][i] <= $signed({1'b0, ww[i]}) * cp[i].x;
        pr[1][i] <= $signed({1'b0, ww[i]}) * cp[i].y;
        pr[2][i] <= $signed({1'b0, ww[i]}) * cp[i].z;
      end
      for (int a = 0; a < 3; a++) begin
        for (int i = 0; i < 8; i++) l1[a][i] <= SUM_W'(pr[a][2*i]) + SUM_W'(pr[a][2*i+1]);
        for (int i = 0; i < 4; i++) l2[a][i] <= l1[a][2*i] + l1[a][2*i+1];
        for (int i = 0; i < 2; i++) l3[a][i] <= l2[a][2*i] + l2[a][2*i+1];
        l4[a] <= l3[a][0] + l3[a][1];
      end
      surf_x       <= to_q16_8(l4[0]);
      surf_y       <= to_q16_8(l4[1]);
      surf_z       <= to_q16_8(l4[2]);
      tex_u        <= tl[13].tu;
      tex_v        <= tl[13].tv;
      vertex_index <= tl[13].vidx;
    end
  end

  // loads write at the stage where evals read, so program order holds
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) cp[i] <= cp_reset(2'(i / 4), 2'(i % 4));
    end else if (adv && sd[8].valid && sd[8].it.kind == KIND_LOAD) begin
      cp[{sd[8].it.row, sd[8].it.col}] <= sd[8].it.pt;
    end
  end

endmodule

`default_nettype wire

[design/bicubic_bezier_surface_eval_top.sv]
// ----------------------------------------------------------------------------
// bicubic_bezier_surface_eval_top: bicubic Bezier surface point generator
// Holds a 4x4 control point grid and streams surface vertices.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): kind 0 loads one control point,
//   kind 1 requests surface point (grid_a, grid_b). Loads give no result.
//   Output channel (out_valid / out_stall): one transaction per eval, in
//   order, with xyz in Q16.8, u/v in Q0.16 and the vertex index.
//   Config channel (cfg_valid / cfg_ready): writes grid_resolution; ready is
//   always high. Write it only while the block is idle.
// Throughput: one transaction per cycle while the output is not stalled, set by
//   the fully pipelined back end (four-stage radix-16 divider, weight multipliers,
//   product tree).
// Stalls: a stalled output freezes the whole back end; the 4-entry queue
//   keeps taking input until full, then in_stall rises.
// Reset (rst, synchronous): resolution 32, control points return to the
//   default grid, queue and pipeline empty. No clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module bicubic_bezier_surface_eval_top (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      in_valid,
  output logic                     in_stall,
  input  wire                      kind,
  input  wire  [1:0]               point_row,
  input  wire  [1:0]               point_col,
  input  wire  signed [15:0]       coord_x,
  input  wire  signed [15:0]       coord_y,
  input  wire  signed [15:0]       coord_z,
  input  wire  [7:0]               grid_a,
  input  wire  [7:0]               grid_b,
  input  wire                      cfg_valid,
  output logic                     cfg_ready,
  input  wire  [bbs_pkg::RES_W-1:0] grid_resolution,
  output logic                     out_valid,
  input  wire                      out_stall,
  output logic signed [23:0]       surf_x,
  output logic signed [23:0]       surf_y,
  output logic signed [23:0]       surf_z,
  output logic [15:0]              tex_u,
  output logic [15:0]              tex_v,
  output logic [15:0]              vertex_index
);
  import bbs_pkg::*;

  logic             q_push;
  logic             q_pop;
  logic             q_full;
  logic             q_empty;
  q_item_t          q_in;
  q_item_t          q_head;
  logic [RES_W-1:0] res_eff;

  // front end: accept and classify
  bbs_front u_front (
    .clk, .rst, .in_valid, .in_stall, .kind, .point_row, .point_col,
    .coord_x, .coord_y, .coord_z, .grid_a, .grid_b,
    .cfg_valid, .cfg_ready, .grid_resolution,
    .q_full, .q_push, .q_item(q_in), .res_eff
  );

  // decoupling queue
  bbs_queue u_queue (
    .clk, .rst, .push(q_push), .push_item(q_in), .pop(q_pop),
    .head(q_head), .full(q_full), .empty(q_empty)
  );

  // back end: evaluate and deliver
  bbs_back u_back (
    .clk, .rst, .head(q_head), .q_empty, .q_pop, .res_eff,
    .out_valid, .out_stall, .surf_x, .surf_y, .surf_z,
    .tex_u, .tex_v, .vertex_index
  );

  // queue never overfilled by the front end
  assert property (@(posedge clk) disable iff (rst) !(q_push && q_full))
    else $error("push into full queue");

  // back end never pops an empty queue
  assert property (@(posedge clk) disable iff (rst) !(q_pop && q_empty))
    else $error("pop from empty queue");

  // a held result that is stalled keeps its surf_x and vertex_index
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(surf_x) && $stable(vertex_index))
    else $error("stalled result changed");

endmodule

`default_nettype wire
